>>> rtl/core/scta_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and key maps of the scan code decoder.
package scta_pkg;

    localparam int FIFO_DEPTH        = 16;
    localparam int PTR_W             = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int KEY_TABLE_ENTRIES = 60;
    localparam int KEY_IDX_W         = $clog2(KEY_TABLE_ENTRIES);

    localparam logic [7:0] CODE_RELEASE_BIT = 8'h80;
    localparam logic [7:0] CODE_LSHIFT_UP   = 8'hAA;
    localparam logic [7:0] CODE_RSHIFT_UP   = 8'hB6;
    localparam logic [7:0] CODE_LSHIFT_DN   = 8'h2A;
    localparam logic [7:0] CODE_RSHIFT_DN   = 8'h36;
    localparam logic [7:0] CODE_CAPS_DN     = 8'h3A;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_READ = 1'b1
    } t_op;

    // Status of one word waiting for its read data from the store.
    typedef struct packed {
        logic char_valid;
        logic fifo_empty;
        logic dropped;
    } t_result;

    // Spanish layout, unshifted. Codes past the printed keys map to zero.
    localparam logic [7:0] PLAIN_MAP [0:KEY_TABLE_ENTRIES-1] = '{
        8'h1B, 8'h40, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h23, 8'h2A, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h60, 8'h2B, 8'h0A, 8'h40,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
        8'h6C, 8'h7B, 8'h23, 8'h7D, 8'h40, 8'h3C,
        8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
        8'h2E, 8'h2D, 8'h40, 8'h40, 8'h40, 8'h20,
        8'h00, 8'h00
    };

    // Spanish layout, shifted.
    localparam logic [7:0] SHIFTED_MAP [0:KEY_TABLE_ENTRIES-1] = '{
        8'h1B, 8'h23, 8'h21, 8'h22, 8'h2D, 8'h24, 8'h25, 8'h26,
        8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h40, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h5E, 8'h2A, 8'h0A, 8'h40,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
        8'h4C, 8'h22, 8'h2B, 8'h40, 8'h40, 8'h3E,
        8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3B,
        8'h3A, 8'h5F, 8'h40, 8'h40, 8'h40, 8'h20,
        8'h00, 8'h00
    };

    // Ring pointer step with wrap at the store depth.
    function automatic t_ptr ptr_advance(input t_ptr p);
        t_ptr result;
        if (p == t_ptr'(FIFO_DEPTH - 1)) begin
            result = '0;
        end else begin
            result = p + t_ptr'(1);
        end
        return result;
    endfunction

endpackage

>>> rtl/core/scan_code_to_ascii_with_fifo.sv
`timescale 1ns / 1ps
// Set-1 scan code to ASCII decoder with a character FIFO held in a small RAM.
//
// The input channel (i_in_valid / o_in_stall) carries one word per cycle unless
// stalled: a scan code arriving from the keyboard (i_operation = scan) or a request
// to pop one character (i_operation = read). Shift and caps lock presses update the
// modifier flags; other pressed keys are mapped through the Spanish key map and
// pushed into a 16-entry character store. A push into a full FIFO is dropped and
// reported through o_dropped; a read of an empty FIFO returns o_char_valid = 0.
//
// Every input word produces exactly one output word on (o_out_valid / i_out_stall).
// The store is a synchronous RAM whose read data is registered in the read stage,
// and the result then goes on to the output register that drives the outputs.
// Pointers and flags are updated at the accept edge, so a new word can be taken
// every cycle while o_in_stall is low, and the sustained rate is one word per
// cycle when the receiver does not stall.
//
// The result passes a read stage and an output register. When the receiver stalls,
// the output register holds and the read stage can still take one more word; the
// input stalls only when both are full. Reset (synchronous, active low) empties
// the FIFO, clears shift and caps, and discards words in flight. The RAM itself
// needs no clearing pass: only written entries are ever popped.
module scan_code_to_ascii_with_fifo (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_operation,
    input  logic [7:0] i_scan_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_char_valid,
    output logic [7:0] o_char_out,
    output logic       o_fifo_empty,
    output logic       o_dropped
);

    // Character store.
    logic [7:0] r_store [0:scta_pkg::FIFO_DEPTH-1];

    // Control state.
    scta_pkg::t_ptr r_wp, n_wp;
    scta_pkg::t_ptr r_rp, n_rp;
    logic           r_shift, n_shift;
    logic           r_caps,  n_caps;

    // Read stage: status plus the registered RAM output.
    logic              r_s1_valid;
    scta_pkg::t_result r_s1;
    scta_pkg::t_result n_s1;
    logic [7:0]        r_rd_data;

    // Output register.
    logic              r_out_valid;
    scta_pkg::t_result r_out;
    logic [7:0]        r_out_char;

    logic       w_in_accept;
    logic       w_s1_move;
    logic       w_is_read;
    logic       w_pop;
    logic       w_push_req;
    logic       w_push_en;
    logic       w_drop;
    logic [7:0] w_key_char;
    scta_pkg::t_ptr w_wp_next;
    logic [scta_pkg::KEY_IDX_W-1:0] w_key_idx;

    // The read stage drains whenever the output register is free or being taken.
    assign w_s1_move   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && r_out_valid && i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_is_read   = (i_operation == scta_pkg::OP_READ);

    // Key map lookup; the index is only used when the code lies inside the map.
    assign w_key_idx  = i_scan_code[scta_pkg::KEY_IDX_W-1:0];
    assign w_key_char = (r_shift != r_caps) ? scta_pkg::SHIFTED_MAP[w_key_idx]
                                            : scta_pkg::PLAIN_MAP[w_key_idx];
    assign w_wp_next  = scta_pkg::ptr_advance(r_wp);

    // Decode of one accepted word: modifier updates, push or pop.
    always_comb begin
        n_shift    = r_shift;
        n_caps     = r_caps;
        n_wp       = r_wp;
        n_rp       = r_rp;
        w_pop      = 1'b0;
        w_push_req = 1'b0;
        if (w_in_accept) begin
            if (w_is_read) begin
                if (r_wp != r_rp) begin
                    w_pop = 1'b1;
                    n_rp  = scta_pkg::ptr_advance(r_rp);
                end
            end else begin
                priority if ((i_scan_code & scta_pkg::CODE_RELEASE_BIT) != 8'h00) begin
                    if (i_scan_code == scta_pkg::CODE_LSHIFT_UP ||
                        i_scan_code == scta_pkg::CODE_RSHIFT_UP) begin
                        n_shift = 1'b0;
                    end
                end else if (i_scan_code == scta_pkg::CODE_LSHIFT_DN ||
                             i_scan_code == scta_pkg::CODE_RSHIFT_DN) begin
                    n_shift = 1'b1;
                end else if (i_scan_code == scta_pkg::CODE_CAPS_DN) begin
                    n_caps = !r_caps;
                end else if (i_scan_code < 8'(scta_pkg::KEY_TABLE_ENTRIES)) begin
                    w_push_req = 1'b1;
                end else begin
                    w_push_req = 1'b0;
                end
            end
        end
        // A full FIFO keeps one slot open; pushing into it is refused.
        w_drop    = w_push_req && (w_wp_next == r_rp);
        w_push_en = w_push_req && !w_drop;
        if (w_push_en) begin
            n_wp = w_wp_next;
        end
        n_s1.char_valid = w_pop;
        n_s1.fifo_empty = (n_wp == n_rp);
        n_s1.dropped    = w_drop;
    end

    // RAM write port.
    always_ff @(posedge i_clk) begin
        if (w_push_en) begin
            r_store[r_wp] <= w_key_char;
        end
    end

    // RAM read port. The data is held until the read stage drains, because a
    // new word is accepted only in a cycle in which the stage moves on.
    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_is_read) begin
            r_rd_data <= r_store[r_rp];
        end
    end

    // Pointers and modifier flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_shift <= n_shift;
            r_caps  <= n_caps;
        end
    end

    // Read stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1 <= n_s1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out      <= r_s1;
            r_out_char <= r_s1.char_valid ? r_rd_data : 8'h00;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_char_valid = r_out.char_valid;
    assign o_char_out   = r_out_char;
    assign o_fifo_empty = r_out.fifo_empty;
    assign o_dropped    = r_out.dropped;

    // A read of a non-empty FIFO must come out of the read stage as a character.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && w_is_read && (r_wp != r_rp)) |=> (r_s1_valid && r_s1.char_valid))
        else $error("pop of a non-empty FIFO lost its character flag");

    // While a popped character waits in the read stage, its RAM data must hold.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.char_valid && !w_s1_move) |=> (r_s1_valid && $stable(r_rd_data)))
        else $error("read data changed while the read stage was held");

    // A dropped push leaves the write pointer where it was.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drop |=> (r_wp == $past(r_wp)))
        else $error("write pointer moved on a dropped push");

    // A drop report never comes with a character.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dropped) |-> (!o_char_valid && (o_char_out == 8'h00)))
        else $error("dropped word also carries a character");

endmodule

>>> tb/sv/key_fifo_check_pkg.sv
`timescale 1ns / 1ps
// Key-map predictor and result scoreboard for the scan code decoder testbench.
package key_fifo_check_pkg;

    import scta_pkg::*;

    // Unshifted Spanish layout, indexed by scan code.
    localparam bit [7:0] PLAIN_KEYS [0:KEY_TABLE_ENTRIES-1] = '{
        8'h1B, 8'h40, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h23, 8'h2A, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h60, 8'h2B, 8'h0A, 8'h40,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
        8'h6C, 8'h7B, 8'h23, 8'h7D, 8'h40, 8'h3C,
        8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
        8'h2E, 8'h2D, 8'h40, 8'h40, 8'h40, 8'h20,
        8'h00, 8'h00
    };

    // Shifted Spanish layout.
    localparam bit [7:0] SHIFTED_KEYS [0:KEY_TABLE_ENTRIES-1] = '{
        8'h1B, 8'h23, 8'h21, 8'h22, 8'h2D, 8'h24, 8'h25, 8'h26,
        8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h40, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h5E, 8'h2A, 8'h0A, 8'h40,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
        8'h4C, 8'h22, 8'h2B, 8'h40, 8'h40, 8'h3E,
        8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3B,
        8'h3A, 8'h5F, 8'h40, 8'h40, 8'h40, 8'h20,
        8'h00, 8'h00
    };

    localparam int unsigned REPORT_LINES = 40;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       fifo_empty;
        logic       dropped;
    } key_result_t;

    class char_fifo_scoreboard;
        bit [7:0]    char_copy [FIFO_DEPTH];
        int unsigned wr_idx;
        int unsigned rd_idx;
        bit          shift_down;
        bit          caps_lock;
        key_result_t awaited [$];
        int unsigned errors;
        int unsigned words_in;
        int unsigned words_out;
        int unsigned chars_read;
        int unsigned empty_reads;
        int unsigned drops;

        function int unsigned fill_level();
            return (wr_idx + FIFO_DEPTH - rd_idx) % FIFO_DEPTH;
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        // Updates the mirrored decoder state and queues the word's expected result.
        function void note_word(t_op op, bit [7:0] code);
            key_result_t want;
            bit          push;
            bit [7:0]    ch;
            int unsigned nxt;
            want = '0;
            push = 1'b0;
            ch   = 8'h00;
            words_in++;
            if (op == OP_READ) begin
                if (wr_idx != rd_idx) begin
                    want.char_valid = 1'b1;
                    want.char_out   = char_copy[rd_idx];
                    rd_idx          = (rd_idx + 1) % FIFO_DEPTH;
                    chars_read++;
                end else begin
                    empty_reads++;
                end
            end else if ((code & CODE_RELEASE_BIT) != 0) begin
                if (code == CODE_LSHIFT_UP || code == CODE_RSHIFT_UP) begin
                    shift_down = 1'b0;
                end
            end else if (code == CODE_LSHIFT_DN || code == CODE_RSHIFT_DN) begin
                shift_down = 1'b1;
            end else if (code == CODE_CAPS_DN) begin
                caps_lock = !caps_lock;
            end else if (code < KEY_TABLE_ENTRIES) begin
                push = 1'b1;
                ch   = (shift_down != caps_lock) ? SHIFTED_KEYS[code] : PLAIN_KEYS[code];
            end
            if (push) begin
                nxt = (wr_idx + 1) % FIFO_DEPTH;
                if (nxt == rd_idx) begin
                    want.dropped = 1'b1;
                    drops++;
                end else begin
                    char_copy[wr_idx] = ch;
                    wr_idx            = nxt;
                end
            end
            want.fifo_empty = (wr_idx == rd_idx);
            awaited.push_back(want);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= REPORT_LINES) begin
                $display("mismatch at result %0d: %s, got %0h, expected %0h",
                         words_out, what, got, want);
            end
        endtask

        task check_word(key_result_t got);
            key_result_t want;
            if (awaited.size() == 0) begin
                report_mismatch("result with nothing awaited", 32'(got), 0);
                return;
            end
            want = awaited.pop_front();
            if (got.char_valid !== want.char_valid) begin
                report_mismatch("char_valid", got.char_valid, want.char_valid);
            end
            if (got.char_out !== want.char_out) begin
                report_mismatch("char_out", got.char_out, want.char_out);
            end
            if (got.fifo_empty !== want.fifo_empty) begin
                report_mismatch("fifo_empty", got.fifo_empty, want.fifo_empty);
            end
            if (got.dropped !== want.dropped) begin
                report_mismatch("dropped", got.dropped, want.dropped);
            end
            words_out++;
        endtask
    endclass

endpackage

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench of the scan code decoder: stimulus, stalls and checking.
module testbench;

    import scta_pkg::*;
    import key_fifo_check_pkg::*;

    // Directed words plus this many random words make up the stimulus.
    localparam int unsigned RANDOM_WORDS = 1650;
    // Tail wait after the last result, to catch stray results.
    localparam int unsigned TAIL_CYCLES  = 20;
    // Far beyond the slowest correct run: every word meeting the longest sender
    // gap and the longest receiver stall still ends well inside this.
    localparam int unsigned LIMIT_CYCLES = 1000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_operation;
    logic [7:0] i_scan_code;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_char_valid;
    logic [7:0] o_char_out;
    logic       o_fifo_empty;
    logic       o_dropped;

    char_fifo_scoreboard sb;
    int unsigned         cycle_count = 0;
    int unsigned         words_sent  = 0;
    // When set, the sender puts no gaps between words.
    bit                  steady_phase;

    scan_code_to_ascii_with_fifo u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_scan_code  (i_scan_code),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_char_valid (o_char_valid),
        .o_char_out   (o_char_out),
        .o_fifo_empty (o_fifo_empty),
        .o_dropped    (o_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, sb.outstanding());
            $display("scan_code_to_ascii_with_fifo regression: fail");
            $finish;
        end
    end

    // Every result taken at a rising edge is compared with the oldest expectation.
    // Outputs only change after the edge, so the values read here are settled.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_word({o_char_valid, o_char_out, o_fifo_empty, o_dropped});
        end
    end

    // Receiver stalls: mostly short bursts, now and then a long one, and from
    // time to time a long stretch with no stall at all.
    initial begin
        int unsigned pick;
        int unsigned run_len;
        int unsigned hold_len;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            pick    = $urandom_range(0, 99);
            run_len = (pick < 8) ? $urandom_range(100, 300) : $urandom_range(0, 12);
            repeat (run_len) @(negedge i_clk) i_out_stall <= 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                hold_len = $urandom_range(1, 3);
            end else if (pick < 95) begin
                hold_len = $urandom_range(4, 12);
            end else begin
                hold_len = $urandom_range(20, 60);
            end
            repeat (hold_len) @(negedge i_clk) i_out_stall <= 1'b1;
        end
    end

    // Presents one word at the falling edge and holds it until the block takes it.
    // A word that follows at once keeps valid high with a single assignment.
    task automatic send_word(t_op op, bit [7:0] code);
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_scan_code <= code;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.note_word(op, code);
        words_sent++;
    endtask

    task automatic pause_sender(int unsigned cycles);
        if (cycles != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Gap before a word: usually none, often a short one, rarely a long one.
    task automatic sender_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (!steady_phase) begin
            if (pick < 60) begin
                pause_sender(0);
            end else if (pick < 90) begin
                pause_sender($urandom_range(1, 3));
            end else if (pick < 98) begin
                pause_sender($urandom_range(4, 12));
            end else begin
                pause_sender($urandom_range(20, 50));
            end
        end
    endtask

    // Sender holds off until every expected result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic read_char();
        sender_gap();
        send_word(OP_READ, 8'($urandom_range(0, 255)));
    endtask

    // A key that lands in the FIFO, never a modifier.
    function automatic bit [7:0] printable_code();
        bit [7:0] code;
        do begin
            code = 8'($urandom_range(0, KEY_TABLE_ENTRIES - 1));
        end while (code == CODE_LSHIFT_DN || code == CODE_RSHIFT_DN || code == CODE_CAPS_DN);
        return code;
    endfunction

    // Code stream as a user types it: mostly keys, some shift and caps traffic,
    // and a little noise from released keys and codes past the table.
    function automatic bit [7:0] typed_code();
        int unsigned pick;
        bit [7:0]    code;
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
            code = printable_code();
        end else if (pick < 76) begin
            code = $urandom_range(0, 1) ? CODE_LSHIFT_DN : CODE_RSHIFT_DN;
        end else if (pick < 84) begin
            code = $urandom_range(0, 1) ? CODE_LSHIFT_UP : CODE_RSHIFT_UP;
        end else if (pick < 89) begin
            code = CODE_CAPS_DN;
        end else if (pick < 95) begin
            code = CODE_RELEASE_BIT | 8'($urandom_range(0, 127));
        end else begin
            code = 8'($urandom_range(KEY_TABLE_ENTRIES, 255));
        end
        return code;
    endfunction

    initial begin
        int unsigned kind;
        int unsigned count;
        int unsigned stop_at;
        sb           = new;
        steady_phase = 1'b1;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_operation  = OP_SCAN;
        i_scan_code  = 8'h00;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, back to back. Both shift keys, caps lock alone and with
        // shift (shift then cancels caps), the last table entry, the first code
        // past the table, ignored releases and the byte extremes.
        send_word(OP_READ, 8'hFF);            // read of an empty FIFO
        send_word(OP_SCAN, 8'h01);
        send_word(OP_SCAN, CODE_LSHIFT_DN);
        send_word(OP_SCAN, 8'h1E);            // shifted letter
        send_word(OP_SCAN, CODE_LSHIFT_UP);
        send_word(OP_SCAN, CODE_RSHIFT_DN);
        send_word(OP_SCAN, 8'h02);            // shifted digit row
        send_word(OP_SCAN, CODE_RSHIFT_UP);
        send_word(OP_SCAN, CODE_CAPS_DN);
        send_word(OP_SCAN, 8'h10);            // caps alone selects the shifted map
        send_word(OP_SCAN, CODE_LSHIFT_DN);
        send_word(OP_SCAN, 8'h1E);            // caps plus shift falls back to plain
        send_word(OP_SCAN, CODE_LSHIFT_UP);
        send_word(OP_SCAN, CODE_CAPS_DN);
        send_word(OP_READ, 8'h00);
        send_word(OP_SCAN, 8'h3B);            // last table entry pushes a zero
        send_word(OP_SCAN, 8'h3C);            // first code past the table
        send_word(OP_SCAN, 8'h7F);
        send_word(OP_SCAN, CODE_RELEASE_BIT); // released key other than shift
        send_word(OP_SCAN, 8'hFF);
        send_word(OP_SCAN, 8'hBA);            // caps release does nothing
        send_word(OP_SCAN, 8'h00);
        while (sb.fill_level() != 0) begin
            send_word(OP_READ, 8'h55);
        end
        send_word(OP_READ, 8'hAA);
        drain_results();

        // Random part, built from bursts: typing runs with reads mixed in, runs
        // that overfill the FIFO and then empty it past the bottom, pure noise,
        // and short read bursts.
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            kind         = $urandom_range(0, 99);
            steady_phase = ($urandom_range(0, 3) == 0);
            if (kind < 55) begin
                count = $urandom_range(1, 12);
                repeat (count) begin
                    sender_gap();
                    send_word(OP_SCAN, typed_code());
                    if ($urandom_range(0, 3) == 0) begin
                        read_char();
                    end
                end
                repeat ($urandom_range(0, count + 2)) read_char();
            end else if (kind < 72) begin
                count = FIFO_DEPTH - 1 - sb.fill_level() + $urandom_range(0, 4);
                repeat (count) begin
                    sender_gap();
                    send_word(OP_SCAN, printable_code());
                end
                repeat (FIFO_DEPTH + $urandom_range(0, 2)) read_char();
            end else if (kind < 88) begin
                repeat ($urandom_range(1, 10)) begin
                    sender_gap();
                    send_word($urandom_range(0, 1) ? OP_READ : OP_SCAN,
                              8'($urandom_range(0, 255)));
                end
            end else begin
                repeat ($urandom_range(1, 6)) read_char();
            end
            if ($urandom_range(0, 14) == 0) begin
                drain_results();
            end
        end

        // Wind down: all results back, then a tail wait to catch strays.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.outstanding() != 0) begin
            sb.report_mismatch("results never delivered", sb.outstanding(), 0);
        end

        $display("covered %0d words and %0d results: %0d characters popped, %0d empty reads,",
                 sb.words_in, sb.words_out, sb.chars_read, sb.empty_reads);
        $display("%0d characters dropped on a full FIFO, %0d mismatches",
                 sb.drops, sb.errors);
        if (sb.errors == 0) begin
            $display("scan_code_to_ascii_with_fifo regression: pass");
        end else begin
            $display("scan_code_to_ascii_with_fifo regression: fail");
        end
        $finish;
    end

endmodule
